@@ rtl/fltt_pkg.sv @@
// fltt_pkg: shared types and constants of the failed-login throttle table
// used by fltt_ctrl, fltt_dp and failed_login_ip_throttle_table; no dependencies

package fltt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int FAIL_W        = 2;

    localparam logic [FAIL_W-1:0] COUNT_MAX   = FAIL_W'(3);
    localparam logic [FAIL_W-1:0] BLOCK_ABOVE = FAIL_W'(2);
    localparam logic [FAIL_W-1:0] COUNT_ONE   = FAIL_W'(1);

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [FAIL_W-1:0] count;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic last_rd;
    } t_dp_sts;

endpackage

@@ rtl/fltt_ctrl.sv @@
// fltt_ctrl: state machine that sequences one table scan per command
// depends on fltt_pkg

module fltt_ctrl
    import fltt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_ctl.load   = 1'b0;
        o_ctl.issue  = 1'b0;
        o_ctl.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_sts.empty ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.issue = 1'b1;
                if (i_sts.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            // last read entry is checked here
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_state == S_IDLE))
        else $error("commit lasted more than one cycle");

    a_drain_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_state == S_SCAN))
        else $error("drain entered without a scan");

endmodule

@@ rtl/fltt_dp.sv @@
// fltt_dp: entry memory, scan counter, match flags and result registers
// depends on fltt_pkg

module fltt_dp
    import fltt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_cmd,
    input  logic [ADDR_W-1:0] i_ip_addr,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    output logic              o_valid,
    output logic              o_blocked,
    output logic              o_dropped
);

    t_entry r_mem [TABLE_ENTRIES];

    t_cmd              r_op;
    logic [ADDR_W-1:0] r_key;
    logic [CNT_W-1:0]  r_used;
    logic [IDX_W-1:0]  r_rd_idx;
    t_entry            r_rd_data;
    logic              r_chk_vld;
    logic [IDX_W-1:0]  r_chk_idx;

    logic              r_hit_fnd;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [FAIL_W-1:0] r_hit_cnt;
    logic              r_zero_fnd;
    logic [IDX_W-1:0]  r_zero_idx;
    logic              r_q_fnd;
    logic              r_q_blk;

    logic              r_res_vld;
    logic              r_blocked;
    logic              r_dropped;

    logic              match;
    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    t_entry            wr_data;

    assign match = (r_rd_data.addr == r_key);
    assign full  = (r_used == CNT_W'(TABLE_ENTRIES));

    assign o_sts.empty   = (r_used == '0);
    assign o_sts.last_rd = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_used);

    // single write port: tick write-back during the scan, record update at commit
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_chk_idx;
        wr_data = r_rd_data;
        if (r_chk_vld && (r_op == CMD_TICK) && (r_rd_data.count != '0)) begin
            wr_en         = 1'b1;
            wr_data.count = r_rd_data.count - COUNT_ONE;
        end else if (i_ctl.commit && (r_op == CMD_RECORD)) begin
            wr_data.addr = r_key;
            if (r_hit_fnd) begin
                wr_en         = 1'b1;
                wr_idx        = r_hit_idx;
                wr_data.count = r_hit_cnt + COUNT_ONE;
            end else if (r_zero_fnd) begin
                wr_en         = 1'b1;
                wr_idx        = r_zero_idx;
                wr_data.count = COUNT_ONE;
            end else if (!full) begin
                wr_en         = 1'b1;
                wr_idx        = r_used[IDX_W-1:0];
                wr_data.count = COUNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (i_ctl.issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op  <= t_cmd'(i_cmd);
            r_key <= i_ip_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_rd_idx   <= '0;
            r_chk_vld  <= 1'b0;
            r_chk_idx  <= '0;
            r_hit_fnd  <= 1'b0;
            r_hit_idx  <= '0;
            r_hit_cnt  <= '0;
            r_zero_fnd <= 1'b0;
            r_zero_idx <= '0;
            r_q_fnd    <= 1'b0;
            r_q_blk    <= 1'b0;
            r_res_vld  <= 1'b0;
            r_blocked  <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            r_chk_vld <= i_ctl.issue;
            r_res_vld <= i_ctl.commit;
            if (i_ctl.load) begin
                r_rd_idx   <= '0;
                r_hit_fnd  <= 1'b0;
                r_zero_fnd <= 1'b0;
                r_q_fnd    <= 1'b0;
                r_q_blk    <= 1'b0;
            end
            if (i_ctl.issue) begin
                r_rd_idx  <= r_rd_idx + IDX_W'(1);
                r_chk_idx <= r_rd_idx;
            end
            if (r_chk_vld) begin
                case (r_op)
                    CMD_RECORD: begin
                        if (!r_hit_fnd && match && (r_rd_data.count < COUNT_MAX)) begin
                            r_hit_fnd <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                            r_hit_cnt <= r_rd_data.count;
                        end
                        if (!r_zero_fnd && (r_rd_data.count == '0)) begin
                            r_zero_fnd <= 1'b1;
                            r_zero_idx <= r_chk_idx;
                        end
                    end
                    CMD_QUERY: begin
                        if (!r_q_fnd && match) begin
                            r_q_fnd <= 1'b1;
                            r_q_blk <= (r_rd_data.count > BLOCK_ABOVE);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.commit) begin
                r_blocked <= (r_op == CMD_QUERY) && r_q_blk;
                r_dropped <= (r_op == CMD_RECORD) && !r_hit_fnd && !r_zero_fnd && full;
                if ((r_op == CMD_RECORD) && !r_hit_fnd && !r_zero_fnd && !full) begin
                    r_used <= r_used + CNT_W'(1);
                end
            end else begin
                r_blocked <= 1'b0;
                r_dropped <= 1'b0;
            end
        end
    end

    assign o_valid   = r_res_vld;
    assign o_blocked = r_blocked;
    assign o_dropped = r_dropped;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_read_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.issue |-> (CNT_W'(r_rd_idx) < r_used))
        else $error("scan read past the entries in use");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> !(r_blocked && r_dropped))
        else $error("result flags both set");

endmodule

@@ rtl/failed_login_ip_throttle_table.sv @@
// failed_login_ip_throttle_table: top level of the failed-login throttle table
// depends on fltt_pkg, fltt_ctrl and fltt_dp
//
// usage:
//   a command transfer is taken on a rising edge with start high and busy low;
//   i_cmd selects record (0), query (1) or decay tick (2), code 3 does nothing;
//   i_ip_addr is the peer address and is ignored on a tick
//   every command gives exactly one result: o_valid is high for one cycle with
//   o_blocked (query answer) and o_dropped (record found a full table)
//   each command scans the entries in use through one read port of the entry
//   memory, one entry a cycle; with n entries in use the result strobe comes
//   n + 2 cycles after the accepting edge (1 when the table is empty) and busy
//   stays high n + 2 cycles (1 when empty), so a command takes n + 3 cycles,
//   at most TABLE_ENTRIES + 3
//   the next command may be taken in the cycle in which the result strobe shows
//   reset clears the in-use count, so the table reads as empty at once and no
//   clearing pass is needed; results cannot be held off by the receiver

module failed_login_ip_throttle_table
    import fltt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [ADDR_W-1:0] i_ip_addr,
    output logic              o_valid,
    output logic              o_blocked,
    output logic              o_dropped
);

    t_dp_ctl dp_ctl;
    t_dp_sts dp_sts;

    fltt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (dp_sts),
        .o_ctl   (dp_ctl)
    );

    fltt_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_ip_addr (i_ip_addr),
        .i_ctl     (dp_ctl),
        .o_sts     (dp_sts),
        .o_valid   (o_valid),
        .o_blocked (o_blocked),
        .o_dropped (o_dropped)
    );

endmodule
